[hw/rtl/sam_pkg.sv]
// Shared types and constants for the surge arrester companion step block.
package sam_pkg;

  localparam int VALUE_WIDTH_DEF   = 48;
  localparam int FRACTION_BITS_DEF = 24;
  localparam int DT_BITS           = 48;
  localparam int MUL_W             = 64;
  localparam int ACC_W             = 2 * MUL_W;
  localparam int STEP_W            = 32;
  localparam int ENERGY_W          = 64;
  localparam int OPCODE_W          = 2;
  localparam int CFG_INDEX_W       = 3;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_COMMIT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CHG_NONE   = 2'd0,
    CHG_ADD    = 2'd1,
    CHG_REMOVE = 2'd2
  } change_t;

  typedef enum logic [2:0] {
    REG_KNEE      = 3'd0,
    REG_GAP       = 3'd1,
    REG_SLOPE     = 3'd2,
    REG_IND       = 3'd3,
    REG_ADMIT     = 3'd4,
    REG_KNEE_BIAS = 3'd5,
    REG_GAP_BIAS  = 3'd6,
    REG_TSTEP     = 3'd7
  } reg_index_t;

  // Operand pairs for the shared multiplier
  typedef enum logic [3:0] {
    MS_VY,   // volts * admittance
    MS_VR,   // slope resistance * drive
    MS_DQ,   // time step * amps, 48 fraction bits
    MS_EN,   // dq * vr, 64-bit saturation
    MS_YZ,   // admittance * inductor impedance
    MS_INJ,  // history * yzl
    MS_YR,   // admittance * slope resistance
    MS_BT,   // yr * bias current
    MS_BTG   // yr * gap bias current
  } mul_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH,
    ST_YR_GO, ST_YR_WAIT, ST_BTG_GO, ST_BTG_WAIT, ST_SPARK,
    ST_VY_GO, ST_VY_WAIT, ST_DRIVE, ST_VR_GO, ST_VR_WAIT,
    ST_DQ_GO, ST_DQ_WAIT, ST_EN_GO, ST_EN_WAIT,
    ST_DIV_GO, ST_DIV_WAIT, ST_YZ_GO, ST_YZ_WAIT,
    ST_INJ_GO, ST_INJ_WAIT, ST_BT_GO, ST_BT_WAIT,
    ST_FINISH, ST_POST
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     div_start;
    logic     ld_amps;
    logic     ld_drive;
    logic     ld_vr;
    logic     ld_dq;
    logic     ld_energy;
    logic     ld_hist;
    logic     ld_yzl;
    logic     ld_inj;
    logic     ld_yr;
    logic     ld_bt;
    logic     spark;
    logic     finish;
    logic     commit;
    logic     clear;
    logic     post;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    cond;
    logic    over_gap;
    logic    zl_nz;
    logic    mul_done;
    logic    div_done;
    logic    out_free;
  } status_t;

endpackage

[hw/rtl/sam_mul.sv]
// Shared signed multiplier: 32x32 partial products accumulated one after another, then round and saturate.
module sam_mul import sam_pkg::*; #(
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [MUL_W-1:0] a,
  input  logic signed [MUL_W-1:0] b,
  input  logic                    sh48,
  input  logic                    wide,
  output logic signed [MUL_W-1:0] res,
  output logic                    done
);

  localparam int HALF = MUL_W / 2;

  logic [MUL_W-1:0] ua, ub;
  logic             neg, sh_hi, wide_r, busy;
  logic [ACC_W-1:0] acc;
  logic [2:0]       cnt;

  logic [HALF-1:0]  ha, hb;
  logic [MUL_W-1:0] pp;
  logic [1:0]       pos_sum;
  logic [ACC_W-1:0] pp_sh, rnd, s, lim;
  logic [MUL_W-1:0] mag_out;

  always_comb begin
    ha = cnt[1] ? ua[MUL_W-1:HALF] : ua[HALF-1:0];
    hb = cnt[0] ? ub[MUL_W-1:HALF] : ub[HALF-1:0];
    pp = ha * hb;
    pos_sum = {1'b0, cnt[1]} + {1'b0, cnt[0]};
    unique case (pos_sum)
      2'd0:    pp_sh = ACC_W'(pp);
      2'd1:    pp_sh = ACC_W'(pp) << HALF;
      default: pp_sh = ACC_W'(pp) << MUL_W;
    endcase
    // round to nearest, ties away from zero (on the magnitude)
    rnd = sh_hi ? acc + (ACC_W'(1) << (DT_BITS - 1))
                : acc + (ACC_W'(1) << (FRACTION_BITS - 1));
    s   = sh_hi ? rnd >> DT_BITS : rnd >> FRACTION_BITS;
    lim = wide_r ? ACC_W'({(MUL_W-1){1'b1}}) : ACC_W'({(VALUE_WIDTH-1){1'b1}});
    if (neg) begin
      mag_out = (s > lim + ACC_W'(1)) ? lim[MUL_W-1:0] + MUL_W'(1) : s[MUL_W-1:0];
    end else begin
      mag_out = (s > lim) ? lim[MUL_W-1:0] : s[MUL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ua     <= a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
        ub     <= b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
        neg    <= a[MUL_W-1] ^ b[MUL_W-1];
        sh_hi  <= sh48;
        wide_r <= wide;
        acc    <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (cnt == 3'd4) begin
          res  <= neg ? -$signed(mag_out) : $signed(mag_out);
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          acc <= acc + pp_sh;
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

endmodule

[hw/rtl/sam_div.sv]
// Restoring divider, one quotient bit per cycle: round(num * 2^FRACTION_BITS / den), saturated.
module sam_div import sam_pkg::*; #(
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [VALUE_WIDTH-1:0] num,
  input  logic        [VALUE_WIDTH-2:0] den,
  output logic signed [VALUE_WIDTH-1:0] res,
  output logic                          done
);

  localparam int VW    = VALUE_WIDTH;
  localparam int NW    = VALUE_WIDTH + FRACTION_BITS;
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    numsh, q;
  logic [VW-1:0]    rem;
  logic [VW-2:0]    den_r;
  logic             neg, busy;
  logic [CNT_W-1:0] cnt;

  logic [VW-1:0]    num_mag, t, den_x;
  logic             ge, up;
  logic [NW:0]      qr, lim;
  logic [VW-1:0]    mag_q;

  always_comb begin
    num_mag = num[VW-1] ? VW'(-num) : VW'(num);
    den_x   = {1'b0, den_r};
    t       = {rem[VW-2:0], numsh[NW-1]};
    ge      = t >= den_x;
    up      = rem >= (den_x - rem);
    qr      = (NW+1)'(q) + (NW+1)'(up);
    lim     = (NW+1)'({(VW-1){1'b1}});
    if (neg) begin
      mag_q = (qr > lim + (NW+1)'(1)) ? lim[VW-1:0] + VW'(1) : qr[VW-1:0];
    end else begin
      mag_q = (qr > lim) ? lim[VW-1:0] : qr[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        numsh <= {num_mag, {FRACTION_BITS{1'b0}}};
        rem   <= '0;
        q     <= '0;
        den_r <= den;
        neg   <= num[VW-1];
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (cnt == CNT_W'(NW)) begin
          res  <= neg ? -$signed(mag_q) : $signed(mag_q);
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          rem   <= ge ? t - den_x : t;
          q     <= {q[NW-2:0], ge};
          numsh <= numsh << 1;
          cnt   <= cnt + CNT_W'(1);
        end
      end
    end
  end

endmodule

[hw/rtl/sam_dp.sv]
// Datapath: configuration registers, arrester state, shared multiplier, divider, result register.
module sam_dp import sam_pkg::*; #(
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int CFG_W = (VALUE_WIDTH - 1 > DT_BITS) ? VALUE_WIDTH - 1 : DT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output status_t                       status,
  input  logic [OPCODE_W-1:0]           in_op,
  input  logic signed [VALUE_WIDTH-1:0] in_volts,
  input  logic [STEP_W-1:0]             in_step,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          o_cond,
  output logic signed [VALUE_WIDTH-1:0] o_inj,
  output logic [1:0]                    o_change,
  output logic                          o_resolve,
  output logic signed [VALUE_WIDTH-1:0] o_dis,
  output logic signed [ENERGY_W-1:0]    o_energy,
  output logic signed [ENERGY_W-1:0]    o_charge,
  output logic signed [VALUE_WIDTH-1:0] o_peak,
  output logic [STEP_W-1:0]             o_pstep,
  output logic [STEP_W-1:0]             o_sstep
);

  localparam int VW = VALUE_WIDTH;

  logic [VW-2:0]      knee, gap, slope, zl, admit, kbias, gbias;
  logic [DT_BITS-1:0] tstep;

  logic signed [VW-1:0] volts, amps, drive, vr, vl, dq, yr, yzl, hist, bias;
  logic signed [VW-1:0] next_inj, past_inj, last_cur, peak, bt, inj;
  logic signed [ENERGY_W-1:0] energy, charge;
  logic [STEP_W-1:0]    step, peak_time, first_time;
  logic                 cond, resolve;
  change_t              change;
  opcode_t              op;

  logic signed [MUL_W-1:0] mul_a, mul_b, mul_res;
  logic signed [VW-1:0]    mul_v, div_res, spark_inj, fin_inj;
  logic                    mul_done, div_done, pos;

  function automatic logic signed [VW-1:0] sat_v(input logic signed [VW:0] x);
    logic signed [VW:0] hi, lo;
    hi = {2'b00, {(VW-1){1'b1}}};
    lo = {2'b11, {(VW-1){1'b0}}};
    if (x > hi) return hi[VW-1:0];
    if (x < lo) return lo[VW-1:0];
    return x[VW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] add_v(input logic signed [VW-1:0] x,
                                                  input logic signed [VW-1:0] y);
    return sat_v((VW+1)'(x) + (VW+1)'(y));
  endfunction

  function automatic logic signed [VW-1:0] sub_v(input logic signed [VW-1:0] x,
                                                  input logic signed [VW-1:0] y);
    return sat_v((VW+1)'(x) - (VW+1)'(y));
  endfunction

  function automatic logic signed [ENERGY_W-1:0] add_e(input logic signed [ENERGY_W-1:0] x,
                                                        input logic signed [ENERGY_W-1:0] y);
    logic signed [ENERGY_W:0] s;
    s = (ENERGY_W+1)'(x) + (ENERGY_W+1)'(y);
    if (s[ENERGY_W] != s[ENERGY_W-1]) return {s[ENERGY_W], {(ENERGY_W-1){~s[ENERGY_W]}}};
    return s[ENERGY_W-1:0];
  endfunction

  function automatic logic [VW-1:0] mag_v(input logic signed [VW-1:0] x);
    return x[VW-1] ? VW'(-x) : VW'(x);
  endfunction

  always_comb begin
    unique case (cmd.mul_sel)
      MS_VY:   begin mul_a = MUL_W'(volts); mul_b = MUL_W'(admit);  end
      MS_VR:   begin mul_a = MUL_W'(slope); mul_b = MUL_W'(drive);  end
      MS_DQ:   begin mul_a = MUL_W'(tstep); mul_b = MUL_W'(amps);   end
      MS_EN:   begin mul_a = MUL_W'(dq);    mul_b = MUL_W'(vr);     end
      MS_YZ:   begin mul_a = MUL_W'(admit); mul_b = MUL_W'(zl);     end
      MS_INJ:  begin mul_a = MUL_W'(hist);  mul_b = MUL_W'(yzl);    end
      MS_YR:   begin mul_a = MUL_W'(admit); mul_b = MUL_W'(slope);  end
      MS_BT:   begin mul_a = MUL_W'(yr);    mul_b = MUL_W'(bias);   end
      MS_BTG:  begin mul_a = MUL_W'(yr);    mul_b = MUL_W'(gbias);  end
      default: begin mul_a = '0;            mul_b = '0;             end
    endcase
  end

  sam_mul #(.VALUE_WIDTH(VALUE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh48  (cmd.mul_sel == MS_DQ),
    .wide  (cmd.mul_sel == MS_EN),
    .res   (mul_res),
    .done  (mul_done)
  );

  sam_div #(.VALUE_WIDTH(VALUE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (vl),
    .den   (zl),
    .res   (div_res),
    .done  (div_done)
  );

  assign mul_v     = mul_res[VW-1:0];
  assign pos       = volts > 0;
  assign spark_inj = pos ? sub_v('0, bt) : bt;
  assign fin_inj   = pos ? sub_v(inj, bt) : add_v(inj, bt);

  always_comb begin
    status.op       = op;
    status.cond     = cond;
    status.over_gap = mag_v(volts) > {1'b0, gap};
    status.zl_nz    = |zl;
    status.mul_done = mul_done;
    status.div_done = div_done;
    status.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      knee <= '0; gap <= '0; slope <= '0; zl <= '0;
      admit <= '0; kbias <= '0; gbias <= '0; tstep <= '0;
      cond <= 1'b0; bias <= '0; hist <= '0;
      next_inj <= '0; past_inj <= '0; last_cur <= '0;
      energy <= '0; charge <= '0; peak <= '0;
      peak_time <= '0; first_time <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (reg_index_t'(cfg_index))
          REG_KNEE:      knee  <= cfg_data[VW-2:0];
          REG_GAP:       gap   <= cfg_data[VW-2:0];
          REG_SLOPE:     slope <= cfg_data[VW-2:0];
          REG_IND:       zl    <= cfg_data[VW-2:0];
          REG_ADMIT:     admit <= cfg_data[VW-2:0];
          REG_KNEE_BIAS: kbias <= cfg_data[VW-2:0];
          REG_GAP_BIAS:  gbias <= cfg_data[VW-2:0];
          REG_TSTEP:     tstep <= cfg_data[DT_BITS-1:0];
          default:       ;
        endcase
      end
      if (cmd.capture) begin
        volts   <= in_volts;
        step    <= in_step;
        op      <= opcode_t'(in_op);
        change  <= CHG_NONE;
        resolve <= 1'b0;
      end
      if (cmd.ld_amps)  amps  <= add_v(mul_v, past_inj);
      if (cmd.ld_drive) drive <= pos ? add_v(amps, bias) : sub_v(amps, bias);
      if (cmd.ld_vr) begin
        vr <= mul_v;
        vl <= sub_v(volts, mul_v);
      end
      if (cmd.ld_dq) begin
        dq       <= mul_v;
        last_cur <= amps;
        bias     <= $signed({1'b0, kbias});
      end
      if (cmd.ld_energy) begin
        energy <= add_e(energy, mul_res);
        charge <= add_e(charge, ENERGY_W'(dq));
      end
      if (cmd.ld_hist) hist <= add_v(amps, div_res);
      if (cmd.ld_yzl)  yzl  <= mul_v;
      if (cmd.ld_inj)  inj  <= mul_v;
      if (cmd.ld_yr)   yr   <= mul_v;
      if (cmd.ld_bt)   bt   <= mul_v;
      if (cmd.spark) begin
        cond     <= 1'b1;
        change   <= CHG_ADD;
        resolve  <= 1'b1;
        bias     <= $signed({1'b0, gbias});
        next_inj <= spark_inj;
        past_inj <= spark_inj;
        if (first_time == '0) first_time <= step;
      end
      if (cmd.finish) begin
        if (mag_v(amps) > mag_v(peak)) begin
          peak      <= amps;
          peak_time <= step;
        end
        // resistive drop under the knee ends conduction
        if (mag_v(vr) < {1'b0, knee}) begin
          cond     <= 1'b0;
          change   <= CHG_REMOVE;
          hist     <= '0;
          next_inj <= '0;
        end else begin
          next_inj <= fin_inj;
        end
      end
      if (cmd.commit) past_inj <= next_inj;
      if (cmd.clear) begin
        cond <= 1'b0; bias <= $signed({1'b0, gbias});
        hist <= '0; next_inj <= '0; past_inj <= '0; last_cur <= '0;
        energy <= '0; charge <= '0; peak <= '0;
        peak_time <= '0; first_time <= '0;
      end
      if (cmd.post) begin
        out_valid <= 1'b1;
        o_cond    <= cond;
        o_inj     <= cond ? past_inj : '0;
        o_change  <= change;
        o_resolve <= resolve;
        o_dis     <= last_cur;
        o_energy  <= energy;
        o_charge  <= charge;
        o_peak    <= peak;
        o_pstep   <= peak_time;
        o_sstep   <= first_time;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/sam_ctrl.sv]
// Controller: sequences the multiplies and the divide of one transaction.
module sam_ctrl import sam_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MS_VY;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status.op)
          OP_CHECK: begin
            if (status.cond)          state_next = ST_VY_GO;
            else if (status.over_gap) state_next = ST_YR_GO;
            else                      state_next = ST_POST;
          end
          OP_COMMIT: begin
            cmd.commit = 1'b1;
            state_next = ST_POST;
          end
          OP_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = ST_POST;
          end
          OP_NONE: state_next = ST_POST;
        endcase
      end
      ST_YR_GO: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_YR; state_next = ST_YR_WAIT;
      end
      ST_YR_WAIT: if (status.mul_done) begin
        cmd.ld_yr  = 1'b1;
        state_next = status.cond ? ST_BT_GO : ST_BTG_GO;
      end
      ST_BTG_GO: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_BTG; state_next = ST_BTG_WAIT;
      end
      ST_BTG_WAIT: if (status.mul_done) begin
        cmd.ld_bt = 1'b1; state_next = ST_SPARK;
      end
      ST_SPARK: begin
        cmd.spark = 1'b1; state_next = ST_POST;
      end
      ST_VY_GO: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_VY; state_next = ST_VY_WAIT;
      end
      ST_VY_WAIT: if (status.mul_done) begin
        cmd.ld_amps = 1'b1; state_next = ST_DRIVE;
      end
      ST_DRIVE: begin
        cmd.ld_drive = 1'b1; state_next = ST_VR_GO;
      end
      ST_VR_GO: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_VR; state_next = ST_VR_WAIT;
      end
      ST_VR_WAIT: if (status.mul_done) begin
        cmd.ld_vr = 1'b1; state_next = ST_DQ_GO;
      end
      ST_DQ_GO: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_DQ; state_next = ST_DQ_WAIT;
      end
      ST_DQ_WAIT: if (status.mul_done) begin
        cmd.ld_dq = 1'b1; state_next = ST_EN_GO;
      end
      ST_EN_GO: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_EN; state_next = ST_EN_WAIT;
      end
      ST_EN_WAIT: if (status.mul_done) begin
        cmd.ld_energy = 1'b1;
        // no inductor: history keeps its value
        state_next    = status.zl_nz ? ST_DIV_GO : ST_YZ_GO;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1; state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: if (status.div_done) begin
        cmd.ld_hist = 1'b1; state_next = ST_YZ_GO;
      end
      ST_YZ_GO: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_YZ; state_next = ST_YZ_WAIT;
      end
      ST_YZ_WAIT: if (status.mul_done) begin
        cmd.ld_yzl = 1'b1; state_next = ST_INJ_GO;
      end
      ST_INJ_GO: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_INJ; state_next = ST_INJ_WAIT;
      end
      ST_INJ_WAIT: if (status.mul_done) begin
        cmd.ld_inj = 1'b1; state_next = ST_YR_GO;
      end
      ST_BT_GO: begin
        cmd.mul_start = 1'b1; cmd.mul_sel = MS_BT; state_next = ST_BT_WAIT;
      end
      ST_BT_WAIT: if (status.mul_done) begin
        cmd.ld_bt = 1'b1; state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1; state_next = ST_POST;
      end
      ST_POST: if (status.out_free) begin
        cmd.post = 1'b1; state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/surge_arrester_companion_step.sv]
// Gapped surge arrester step: one transaction in, one result out through an output register.
// A commit, clear, unused opcode or quiet check goes straight to posting; a sparkover runs two
// multiplies, and a conducting check runs 8 multiplies and, with a nonzero inductor impedance,
// the divider. One transaction at a time; the next is accepted the cycle after the result is
// posted, and posting waits while the previous result is held. Reset (rst, sync) clears config
// and state.
module surge_arrester_companion_step import sam_pkg::*; #(
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int IN_W  = ((VALUE_WIDTH + STEP_W + 7) / 8) * 8,
  localparam int RES_W = 4 + 3 * VALUE_WIDTH + 2 * ENERGY_W + 2 * STEP_W,
  localparam int OUT_W = ((RES_W + 7) / 8) * 8,
  localparam int CFG_W = (VALUE_WIDTH - 1 > DT_BITS) ? VALUE_WIDTH - 1 : DT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_W-1:0]        s_tdata,   // branch_voltage, step_number
  input  logic [OPCODE_W-1:0]    s_tuser,   // opcode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_W-1:0]       m_tdata,   // is_conducting, injection_current,
                                            // admittance_change, resolve_request,
                                            // discharge_current, energy_total, charge_total,
                                            // peak_current, peak_step, start_step
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  cmd_t    cmd;
  status_t status;

  logic                          o_cond, o_resolve;
  logic signed [VALUE_WIDTH-1:0] o_inj, o_dis, o_peak;
  logic [1:0]                    o_change;
  logic signed [ENERGY_W-1:0]    o_energy, o_charge;
  logic [STEP_W-1:0]             o_pstep, o_sstep;

  assign cfg_ready = 1'b1;

  sam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sam_dp #(.VALUE_WIDTH(VALUE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_op     (s_tuser),
    .in_volts  (s_tdata[VALUE_WIDTH-1:0]),
    .in_step   (s_tdata[VALUE_WIDTH+STEP_W-1:VALUE_WIDTH]),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .o_cond    (o_cond),
    .o_inj     (o_inj),
    .o_change  (o_change),
    .o_resolve (o_resolve),
    .o_dis     (o_dis),
    .o_energy  (o_energy),
    .o_charge  (o_charge),
    .o_peak    (o_peak),
    .o_pstep   (o_pstep),
    .o_sstep   (o_sstep)
  );

  assign m_tdata = OUT_W'({o_sstep, o_pstep, o_peak, o_charge, o_energy, o_dis,
                           o_resolve, o_change, o_inj, o_cond});

endmodule
